/* hdl/battery_calibration_sequencer_unit_defines.svh */
// Assertion macros for the battery calibration sequencer port checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BATTERY_CALIBRATION_SEQUENCER_UNIT_DEFINES_SVH
`define BATTERY_CALIBRATION_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bcs_pkg.sv */
// Types and constants for the battery calibration sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int unsigned LevelW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [LevelW-1:0] PctMax = LevelW'(100);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_CHARGE1     = 3'd1,
    PH_WAIT_UNPLUG = 3'd2,
    PH_DISCHARGE   = 3'd3,
    PH_WAIT_PLUG   = 3'd4,
    PH_CHARGE2     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_DELAY  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PROF_NONE    = 2'd0,
    PROF_LOW_ON  = 2'd1,
    PROF_LOW_OFF = 2'd2,
    PROF_PERF    = 2'd3
  } prof_e;

  typedef enum logic [2:0] {
    OUT_NONE   = 3'd0,
    OUT_CANCEL = 3'd1,
    OUT_ABORT1 = 3'd2,
    OUT_ABORT2 = 3'd3,
    OUT_ABORT3 = 3'd4,
    OUT_DONE   = 3'd5
  } outcome_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL    = 2'd0,
    CFG_EMPTY   = 2'd1,
    CFG_SUSPEND = 2'd2,
    CFG_BRIGHT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [LevelW-1:0] percentage;
    logic [1:0]        charging_state;
    logic [LevelW-1:0] current_brightness;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic              brightness_valid;
    logic [LevelW-1:0] brightness;
    logic [1:0]        profile_cmd;
    logic              load_enable;
    logic              start_delay;
    logic              alert_beep;
    logic              suspend_request;
    logic [2:0]        outcome;
  } out_item_t;

  typedef struct packed {
    logic [LevelW-1:0] full_level;
    logic [LevelW-1:0] empty_level;
    logic [LevelW-1:0] suspend_level;
    logic [LevelW-1:0] bright_level;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic              started_charging;
    logic              delay_pending;
    logic [LevelW-1:0] saved_brightness;
    logic              load_on;
  } seq_state_t;

endpackage

/* hdl/battery_calibration_sequencer_unit.sv */
// Pipeline: an accepted transaction is registered in the input stage, stepped and then
//   registered in the output stage; a stalled output holds it in the input stage.
// Throughput: one event per cycle while out_stall_i is low; step logic sits between them.
// Reset (rst_ni low, asynchronous): phase inactive, load off, saved brightness 100,
//   configuration levels at full 100, empty 3, suspend 2, bright 100; both stages empty.
`timescale 1ns / 1ps
module battery_calibration_sequencer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // event channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bcs_pkg::in_item_t            in_data_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bcs_pkg::out_item_t           out_data_o,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [bcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bcs_pkg::LevelW-1:0]   cfg_wdata_i
);
  import bcs_pkg::*;

  // Input stage: holds one accepted event until the step logic consumes it.
  logic      in_valid_q, in_valid_d;
  in_item_t  in_data_q;
  // Output stage: holds one result until the consumer takes it.
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  logic      in_accept;
  logic      out_taken;
  logic      fire;
  cfg_t      cfg;
  out_item_t step_result;

  // Step the held event when the output register is empty or being drained.
  assign out_taken  = out_valid_q && !out_stall_i;
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= step_result;
    end
  end

  bcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/bcs_cfg_regs.sv */
// Configuration registers of the battery calibration sequencer.
// Depends on bcs_pkg.
`timescale 1ns / 1ps
module bcs_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bcs_pkg::LevelW-1:0]   cfg_wdata_i,
  output bcs_pkg::cfg_t                cfg_o
);
  import bcs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FULL:    cfg_d.full_level    = cfg_wdata_i;
        CFG_EMPTY:   cfg_d.empty_level   = cfg_wdata_i;
        CFG_SUSPEND: cfg_d.suspend_level = cfg_wdata_i;
        CFG_BRIGHT:  cfg_d.bright_level  = cfg_wdata_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_level    <= PctMax;
      cfg_q.empty_level   <= LevelW'(3);
      cfg_q.suspend_level <= LevelW'(2);
      cfg_q.bright_level  <= PctMax;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/bcs_core.sv */
// Phase state and per-event step logic of the calibration sequencer.
// Depends on bcs_pkg; state advances when fire_i is high.
`timescale 1ns / 1ps
module bcs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  bcs_pkg::in_item_t   item_i,
  input  bcs_pkg::cfg_t       cfg_i,
  output bcs_pkg::out_item_t  result_o
);
  import bcs_pkg::*;

  seq_state_t st_q, st_d;

  logic              plugged;
  logic              fin;
  outcome_e          fin_code;
  logic [LevelW-1:0] unplug_bright;

  assign plugged       = |item_i.charging_state;
  assign unplug_bright = (item_i.percentage > PctMax) ? PctMax : item_i.percentage;

  always_comb begin
    st_d     = st_q;
    fin      = 1'b0;
    fin_code = OUT_NONE;
    result_o = '0;

    case (kind_e'(item_i.kind))
      KIND_START: begin
        if (st_q.phase == PH_IDLE) begin
          st_d.started_charging = 1'b0;
          st_d.delay_pending    = 1'b0;
          st_d.saved_brightness = item_i.current_brightness;
          st_d.phase            = PH_CHARGE1;
          result_o.brightness_valid = 1'b1;
          result_o.brightness       = cfg_i.bright_level;
        end
      end
      KIND_CANCEL: begin
        if (st_q.phase != PH_IDLE) begin
          fin      = 1'b1;
          fin_code = OUT_CANCEL;
        end
      end
      KIND_STATUS: begin
        case (st_q.phase)
          PH_CHARGE1: begin
            if (plugged) begin
              st_d.started_charging     = 1'b1;
              result_o.profile_cmd      = PROF_LOW_ON;
              result_o.brightness_valid = 1'b1;
              result_o.brightness       = cfg_i.bright_level;
              if (item_i.percentage == cfg_i.full_level && !st_q.delay_pending) begin
                st_d.delay_pending   = 1'b1;
                result_o.start_delay = 1'b1;
              end
            end else if (st_q.started_charging) begin
              fin      = 1'b1;
              fin_code = OUT_ABORT1;
            end else begin
              result_o.brightness_valid = 1'b1;
              result_o.brightness       = cfg_i.bright_level;
            end
          end
          PH_WAIT_UNPLUG: begin
            result_o.brightness_valid = 1'b1;
            if (!plugged) begin
              st_d.phase           = PH_DISCHARGE;
              st_d.load_on         = 1'b1;
              result_o.profile_cmd = PROF_PERF;
              result_o.brightness  = unplug_bright;
            end else begin
              result_o.brightness = cfg_i.bright_level;
            end
          end
          PH_DISCHARGE: begin
            if (plugged) begin
              fin      = 1'b1;
              fin_code = OUT_ABORT2;
            end else if (item_i.percentage <= cfg_i.empty_level) begin
              // Empty reached: stop the load and prompt for the charger.
              st_d.load_on              = 1'b0;
              st_d.phase                = PH_WAIT_PLUG;
              result_o.profile_cmd      = PROF_LOW_ON;
              result_o.brightness_valid = 1'b1;
              result_o.brightness       = cfg_i.bright_level;
              result_o.alert_beep       = 1'b1;
            end
          end
          PH_WAIT_PLUG: begin
            result_o.brightness_valid = 1'b1;
            result_o.brightness       = cfg_i.bright_level;
            if (plugged) begin
              st_d.phase = PH_CHARGE2;
            end else if (item_i.percentage <= cfg_i.suspend_level) begin
              result_o.suspend_request = 1'b1;
            end
          end
          PH_CHARGE2: begin
            if (!plugged) begin
              fin      = 1'b1;
              fin_code = OUT_ABORT3;
            end else if (item_i.percentage == cfg_i.full_level) begin
              fin                 = 1'b1;
              fin_code            = OUT_DONE;
              result_o.alert_beep = 1'b1;
            end
          end
          default: begin
            st_d = st_q;
          end
        endcase
      end
      KIND_DELAY: begin
        if (st_q.phase == PH_CHARGE1 && st_q.delay_pending) begin
          st_d.delay_pending        = 1'b0;
          st_d.phase                = PH_WAIT_UNPLUG;
          result_o.brightness_valid = 1'b1;
          result_o.brightness       = cfg_i.bright_level;
          result_o.alert_beep       = 1'b1;
        end
      end
      default: begin
        st_d = st_q;
      end
    endcase

    // End of calibration: stop load, drop low profile, restore brightness.
    if (fin) begin
      st_d.load_on              = 1'b0;
      st_d.delay_pending        = 1'b0;
      st_d.phase                = PH_IDLE;
      result_o.profile_cmd      = PROF_LOW_OFF;
      result_o.brightness_valid = 1'b1;
      result_o.brightness       = st_q.saved_brightness;
      result_o.outcome          = fin_code;
    end

    result_o.phase       = st_d.phase;
    result_o.load_enable = st_d.load_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase            <= PH_IDLE;
      st_q.started_charging <= 1'b0;
      st_q.delay_pending    <= 1'b0;
      st_q.saved_brightness <= PctMax;
      st_q.load_on          <= 1'b0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

/* hdl/bcs_checker.sv */
// Port-level checker for the battery calibration sequencer, bound to the top level.
// Depends on bcs_pkg and battery_calibration_sequencer_unit_defines.svh.
`timescale 1ns / 1ps
`include "battery_calibration_sequencer_unit_defines.svh"
module bcs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input bcs_pkg::out_item_t           out_data_o
);
  import bcs_pkg::*;

  // Hold a stalled result.
  `BCS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  // An ending outcome leaves the sequencer inactive.
  `BCS_ASSERT(a_end_idle, out_valid_o && (out_data_o.outcome != OUT_NONE), out_data_o.phase == PH_IDLE, "outcome without return to inactive")
  // An ending outcome stops the load, drops the low profile and restores brightness.
  `BCS_ASSERT(a_end_cleanup, out_valid_o && (out_data_o.outcome != OUT_NONE), out_data_o.brightness_valid && (out_data_o.profile_cmd == PROF_LOW_OFF) && !out_data_o.load_enable, "end of calibration without cleanup")
  // Load runs only in the discharge phase.
  `BCS_ASSERT(a_load_phase, out_valid_o && out_data_o.load_enable, out_data_o.phase == PH_DISCHARGE, "load enabled outside discharge")
  // No brightness value without a brightness command.
  `BCS_ASSERT(a_bright_zero, out_valid_o && !out_data_o.brightness_valid, out_data_o.brightness == '0, "brightness value without command")

endmodule

bind battery_calibration_sequencer_unit bcs_checker u_bcs_checker (.*);

/* dv/battery_calibration_sequencer_unit_checker.sv */
// Checker for the battery calibration sequencer: watches the event, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on bcs_pkg for the transaction types and codes.
`timescale 1ns / 1ps
module battery_calibration_sequencer_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ev_valid_i,
  input  logic                          ev_stall_i,
  input  bcs_pkg::in_item_t             ev_data_i,
  input  logic                          res_valid_i,
  input  logic                          res_stall_i,
  input  bcs_pkg::out_item_t            res_data_i,
  input  logic                          cfg_we_i,
  input  logic [bcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcs_pkg::LevelW-1:0]    cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bcs_pkg::*;

  // Predicted sequencer state and level settings.
  phase_e            phase_q;
  logic              started_q;
  logic              delay_q;
  logic              load_q;
  logic [LevelW-1:0] saved_q;
  logic [LevelW-1:0] full_q;
  logic [LevelW-1:0] empty_q;
  logic [LevelW-1:0] susp_q;
  logic [LevelW-1:0] bright_q;

  out_item_t   expected_q[$];
  int unsigned mismatch_cnt;

  function automatic void end_calibration(inout out_item_t r, input outcome_e code);
    load_q             = 1'b0;
    delay_q            = 1'b0;
    phase_q            = PH_IDLE;
    r.profile_cmd      = PROF_LOW_OFF;
    r.brightness_valid = 1'b1;
    r.brightness       = saved_q;
    r.outcome          = code;
  endfunction

  function automatic out_item_t predict_event(in_item_t ev);
    out_item_t r;
    logic      plugged;
    r       = '0;
    plugged = (ev.charging_state != 2'd0);
    case (kind_e'(ev.kind))
      KIND_START: begin
        if (phase_q == PH_IDLE) begin
          started_q          = 1'b0;
          delay_q            = 1'b0;
          saved_q            = ev.current_brightness;
          phase_q            = PH_CHARGE1;
          r.brightness_valid = 1'b1;
          r.brightness       = bright_q;
        end
      end
      KIND_CANCEL: begin
        if (phase_q != PH_IDLE) end_calibration(r, OUT_CANCEL);
      end
      KIND_STATUS: begin
        case (phase_q)
          PH_CHARGE1: begin
            if (plugged) begin
              started_q          = 1'b1;
              r.profile_cmd      = PROF_LOW_ON;
              r.brightness_valid = 1'b1;
              r.brightness       = bright_q;
              if (ev.percentage == full_q && !delay_q) begin
                delay_q       = 1'b1;
                r.start_delay = 1'b1;
              end
            end else if (started_q) begin
              end_calibration(r, OUT_ABORT1);
            end else begin
              r.brightness_valid = 1'b1;
              r.brightness       = bright_q;
            end
          end
          PH_WAIT_UNPLUG: begin
            r.brightness_valid = 1'b1;
            if (!plugged) begin
              phase_q       = PH_DISCHARGE;
              load_q        = 1'b1;
              r.profile_cmd = PROF_PERF;
              r.brightness  = (ev.percentage > PctMax) ? PctMax : ev.percentage;
            end else begin
              r.brightness = bright_q;
            end
          end
          PH_DISCHARGE: begin
            if (plugged) begin
              end_calibration(r, OUT_ABORT2);
            end else if (ev.percentage <= empty_q) begin
              load_q             = 1'b0;
              r.profile_cmd      = PROF_LOW_ON;
              r.brightness_valid = 1'b1;
              r.brightness       = bright_q;
              r.alert_beep       = 1'b1;
              phase_q            = PH_WAIT_PLUG;
            end
          end
          PH_WAIT_PLUG: begin
            r.brightness_valid = 1'b1;
            r.brightness       = bright_q;
            if (plugged) phase_q = PH_CHARGE2;
            else if (ev.percentage <= susp_q) r.suspend_request = 1'b1;
          end
          PH_CHARGE2: begin
            if (!plugged) begin
              end_calibration(r, OUT_ABORT3);
            end else if (ev.percentage == full_q) begin
              end_calibration(r, OUT_DONE);
              r.alert_beep = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase_q == PH_CHARGE1 && delay_q) begin
          delay_q            = 1'b0;
          phase_q            = PH_WAIT_UNPLUG;
          r.brightness_valid = 1'b1;
          r.brightness       = bright_q;
          r.alert_beep       = 1'b1;
        end
      end
    endcase
    r.phase       = phase_q;
    r.load_enable = load_q;
    return r;
  endfunction

  function automatic int unsigned diff_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      phase_q      = PH_IDLE;
      started_q    = 1'b0;
      delay_q      = 1'b0;
      load_q       = 1'b0;
      saved_q      = PctMax;
      full_q       = LevelW'(100);
      empty_q      = LevelW'(3);
      susp_q       = LevelW'(2);
      bright_q     = LevelW'(100);
      mismatch_cnt = 0;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FULL:    full_q   = cfg_wdata_i;
          CFG_EMPTY:   empty_q  = cfg_wdata_i;
          CFG_SUSPEND: susp_q   = cfg_wdata_i;
          default:     bright_q = cfg_wdata_i;
        endcase
      end
      if (res_valid_i && !res_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, res_data_i);
          mismatch_cnt++;
        end else begin
          want = expected_q.pop_front();
          mismatch_cnt += diff_field("phase", 8'(want.phase), 8'(res_data_i.phase));
          mismatch_cnt += diff_field("brightness_valid", 8'(want.brightness_valid),
                                     8'(res_data_i.brightness_valid));
          mismatch_cnt += diff_field("brightness", 8'(want.brightness),
                                     8'(res_data_i.brightness));
          mismatch_cnt += diff_field("profile_cmd", 8'(want.profile_cmd),
                                     8'(res_data_i.profile_cmd));
          mismatch_cnt += diff_field("load_enable", 8'(want.load_enable),
                                     8'(res_data_i.load_enable));
          mismatch_cnt += diff_field("start_delay", 8'(want.start_delay),
                                     8'(res_data_i.start_delay));
          mismatch_cnt += diff_field("alert_beep", 8'(want.alert_beep),
                                     8'(res_data_i.alert_beep));
          mismatch_cnt += diff_field("suspend_request", 8'(want.suspend_request),
                                     8'(res_data_i.suspend_request));
          mismatch_cnt += diff_field("outcome", 8'(want.outcome), 8'(res_data_i.outcome));
        end
      end
      if (ev_valid_i && !ev_stall_i) expected_q.push_back(predict_event(ev_data_i));
      pending_o    <= expected_q.size();
      fail_count_o <= mismatch_cnt;
    end
  end

endmodule

/* dv/battery_calibration_sequencer_unit_tb.sv */
// Testbench top for the battery calibration sequencer: clock, reset, event and
// level-register stimulus, receiver stalls and the final verdict.
// Depends on bcs_pkg, the sequencer RTL and battery_calibration_sequencer_unit_checker.
`timescale 1ns / 1ps
module battery_calibration_sequencer_unit_tb;
  import bcs_pkg::*;

  // Charging states as the event carries them; any nonzero value means mains present.
  localparam int unsigned CS_DISCHARGING = 0;
  localparam int unsigned CS_CHARGING    = 1;
  localparam int unsigned CS_CHARGED     = 2;
  localparam int unsigned CS_ODD         = 3;

  localparam int unsigned PCT_TOP   = 127;  // largest value a 7-bit level can carry
  localparam int unsigned HOLD_LEN  = 400;  // cycles of the long receiver hold-off
  localparam int unsigned ROUND_LEN = 85;   // least number of events per random round

  logic                clk;
  logic                rst_n;
  logic                ev_valid;
  logic                ev_stall;
  in_item_t            ev_data;
  logic                res_valid;
  logic                res_stall;
  out_item_t           res_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [LevelW-1:0]   cfg_wdata;
  int unsigned         fail_count;
  int unsigned         pending;

  // Idling controls shared with the receiver process.
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  logic        hold_req        = 1'b0;

  // Level settings as last programmed; shape the well-formed calibration runs.
  int unsigned full_lv    = 100;
  int unsigned empty_lv   = 3;
  int unsigned suspend_lv = 2;
  int unsigned sent_cnt   = 0;

  battery_calibration_sequencer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_data),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  battery_calibration_sequencer_unit_checker u_sequence_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .ev_valid_i   (ev_valid),
    .ev_stall_i   (ev_stall),
    .ev_data_i    (ev_data),
    .res_valid_i  (res_valid),
    .res_stall_i  (res_stall),
    .res_data_i   (res_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a transaction.
  initial begin
    #3_000_000;
    $display("battery_calibration_sequencer_unit: mismatch");
    $finish;
  end

  // Receiver: stall at random per the current mode; on request, hold off once for a
  // long stretch so the pipeline fills and the event channel backs up.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t make_event(kind_e k, int unsigned pct, int unsigned cs,
                                          int unsigned cur);
    in_item_t ev;
    ev.kind               = k;
    ev.percentage         = pct[LevelW-1:0];
    ev.charging_state     = cs[1:0];
    ev.current_brightness = cur[LevelW-1:0];
    return ev;
  endfunction

  function automatic int unsigned rand_pct();
    return $urandom_range(PCT_TOP);
  endfunction

  // Any percentage but the given level.
  function automatic int unsigned pct_other_than(int unsigned lvl);
    int unsigned v;
    v = rand_pct();
    if (v == lvl) v = v ^ 1;
    return v;
  endfunction

  function automatic int unsigned plugged_cs();
    return $urandom_range(CS_ODD, CS_CHARGING);
  endfunction

  // Offer one transaction, idling first at the sender's rate; return once accepted.
  // Valid stays high on return so back-to-back transactions need no extra edge.
  task automatic send_event(input in_item_t ev);
    while ($urandom_range(99) < sender_idle_pct) begin
      ev_valid <= 1'b0;
      @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_data  <= ev;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_status(int unsigned pct, int unsigned cs);
    send_event(make_event(KIND_STATUS, pct, cs, rand_pct()));
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic quiesce();
    ev_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_level(cfg_idx_e idx, int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[LevelW-1:0];
    @(posedge clk);
  endtask

  // Program all four levels; call only while the block is idle.
  task automatic program_levels(int unsigned f, int unsigned e, int unsigned s,
                                int unsigned b);
    write_level(CFG_FULL, f);
    write_level(CFG_EMPTY, e);
    write_level(CFG_SUSPEND, s);
    write_level(CFG_BRIGHT, b);
    cfg_we     <= 1'b0;
    full_lv    = f;
    empty_lv   = e;
    suspend_lv = s;
  endtask

  // One calibration run with random content; a few runs break off early
  // (unplug in charge, plug in discharge, unplug in final charge, cancel).
  task automatic run_calibration();
    send_event(make_event(KIND_START, rand_pct(), $urandom_range(3), rand_pct()));
    // prompt to plug in before any charging was seen
    if ($urandom_range(3) == 0) send_status(rand_pct(), CS_DISCHARGING);
    repeat ($urandom_range(3)) send_status(pct_other_than(full_lv), plugged_cs());
    if ($urandom_range(9) == 0) begin
      send_status(rand_pct(), CS_DISCHARGING);
      return;
    end
    if ($urandom_range(19) == 0) begin
      send_event(make_event(KIND_CANCEL, rand_pct(), $urandom_range(3), rand_pct()));
      return;
    end
    // full may be reported more than once; the delay is asked for only once
    repeat ($urandom_range(2, 1)) send_status(full_lv, plugged_cs());
    send_event(make_event(KIND_DELAY, rand_pct(), $urandom_range(3), rand_pct()));
    repeat ($urandom_range(2)) send_status(rand_pct(), plugged_cs());
    send_status(rand_pct(), CS_DISCHARGING);
    if (empty_lv < PCT_TOP) begin
      repeat ($urandom_range(4)) send_status($urandom_range(PCT_TOP, empty_lv + 1),
                                             CS_DISCHARGING);
    end
    if ($urandom_range(9) == 0) begin
      send_status(rand_pct(), plugged_cs());
      return;
    end
    send_status($urandom_range(empty_lv), CS_DISCHARGING);
    repeat ($urandom_range(3)) send_status(rand_pct(), CS_DISCHARGING);
    if ($urandom_range(1) == 0) send_status($urandom_range(suspend_lv), CS_DISCHARGING);
    send_status(rand_pct(), plugged_cs());
    repeat ($urandom_range(3)) send_status(pct_other_than(full_lv), plugged_cs());
    if ($urandom_range(9) == 0) begin
      send_status(rand_pct(), CS_DISCHARGING);
      return;
    end
    send_status(full_lv, plugged_cs());
  endtask

  initial begin
    int unsigned round_base;
    rst_n     = 1'b0;
    ev_valid  <= 1'b0;
    ev_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FULL;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset levels (full 100, empty 3, suspend 2, bright 100).
    send_event(make_event(KIND_CANCEL, 0, CS_DISCHARGING, 0));    // ignored while inactive
    send_status(50, CS_CHARGING);                                 // ignored while inactive
    send_event(make_event(KIND_DELAY, 0, CS_DISCHARGING, 0));     // ignored while inactive
    send_event(make_event(KIND_START, 0, CS_DISCHARGING, 127));   // save brightness 127
    send_event(make_event(KIND_START, 100, CS_CHARGED, 5));       // ignored while active
    send_event(make_event(KIND_DELAY, 0, CS_DISCHARGING, 0));     // no delay pending yet
    send_status(40, CS_DISCHARGING);                              // plug-in prompt
    send_status(50, CS_ODD);                                      // odd state counts as mains
    send_status(100, CS_CHARGING);                                // full: request delay
    send_status(100, CS_CHARGED);                                 // full again: no new delay
    send_event(make_event(KIND_DELAY, 0, CS_DISCHARGING, 0));     // advance to wait unplug
    send_status(100, CS_CHARGING);                                // still plugged
    send_status(127, CS_DISCHARGING);                             // unplug, brightness saturates
    send_status(50, CS_DISCHARGING);                              // discharging, nothing new
    send_status(3, CS_DISCHARGING);                               // empty: wait for plug
    send_status(2, CS_DISCHARGING);                               // at suspend level
    send_status(0, CS_DISCHARGING);                               // below suspend level
    send_status(10, CS_ODD);                                      // plug: final charge
    send_event(make_event(KIND_DELAY, 0, CS_DISCHARGING, 0));     // delay outside charge1
    send_status(100, CS_CHARGED);                                 // completed, restore 127
    send_event(make_event(KIND_START, 127, CS_ODD, 0));
    send_status(10, CS_CHARGING);
    send_status(10, CS_DISCHARGING);                              // unplug after charging
    send_event(make_event(KIND_START, 0, CS_DISCHARGING, 64));
    send_event(make_event(KIND_CANCEL, 127, CS_ODD, 127));

    // Random rounds: each with its own levels and idling mode.
    for (int unsigned round_idx = 0; round_idx < 8; round_idx++) begin
      quiesce();
      case (round_idx)
        0:       program_levels(100, 3, 2, 100);
        1:       program_levels(0, 0, 0, 0);
        2:       program_levels(PCT_TOP, PCT_TOP, PCT_TOP, PCT_TOP);
        3:       program_levels(100, 100, 100, 100);
        default: program_levels($urandom_range(100), $urandom_range(100),
                                $urandom_range(100), $urandom_range(PCT_TOP));
      endcase
      case (round_idx % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 51; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 51; end
        default: begin sender_idle_pct = 17; stall_pct = 17; end
      endcase
      // Back up the block once: the receiver holds off while events keep coming.
      if (round_idx == 2) hold_req = 1'b1;
      round_base = sent_cnt;
      while (sent_cnt - round_base < ROUND_LEN) begin
        if ($urandom_range(3) != 0) begin
          run_calibration();
        end else begin
          repeat ($urandom_range(3, 1))
            send_event(make_event(kind_e'($urandom_range(3)), rand_pct(),
                                  $urandom_range(3), rand_pct()));
        end
      end
    end

    // Drain: no more idling, collect every outstanding result, then a short tail.
    sender_idle_pct = 0;
    stall_pct       = 0;
    quiesce();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("battery_calibration_sequencer_unit: match");
    end else begin
      $display("battery_calibration_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/bcs_pkg.sv
hdl/bcs_cfg_regs.sv
hdl/bcs_core.sv
hdl/battery_calibration_sequencer_unit.sv
hdl/bcs_checker.sv
dv/battery_calibration_sequencer_unit_checker.sv
dv/battery_calibration_sequencer_unit_tb.sv
